[src/mdf_pkg.sv]
package mdf_pkg;

  // window and sample sizing
  localparam int WINDOW_DEPTH = 32;
  localparam int SAMPLE_BITS  = 24;

  // derived widths
  localparam int IDX_BITS  = $clog2(WINDOW_DEPTH);
  localparam int CNT_BITS  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  // stream data widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + DIFF_BITS + 7) / 8) * 8;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // capture sample, ring read issued
    logic update;    // running sum, ring write, index and count advance
    logic load;      // load divider with magnitude and sign of the sum
    logic step;      // one quotient bit
    logic load_out;  // latch average and difference into output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;  // current divide step is the final one
  } status_t;

endpackage

[src/mdf_ram.sv]
module mdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/mdf_ctrl.sv]
module mdf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output mdf_pkg::cmd_t   cmd,
  input  mdf_pkg::status_t status
);

  typedef enum logic [2:0] {
    IDLE,
    UPDATE,
    LOAD,
    DIVIDE,
    FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == IDLE);
  assign out_free = !m_tvalid || m_tready;

  // commands decoded from state
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == IDLE) && s_tvalid;
    cmd.update   = (state == UPDATE);
    cmd.load     = (state == LOAD);
    cmd.step     = (state == DIVIDE);
    cmd.load_out = (state == FINISH) && out_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= UPDATE;
          end
        end
        UPDATE: state <= LOAD;
        LOAD:   state <= DIVIDE;
        DIVIDE: begin
          if (status.div_last) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase

      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[src/mdf_datapath.sv]
module mdf_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  mdf_pkg::cmd_t                    cmd,
  output mdf_pkg::status_t                 status,
  input  logic [mdf_pkg::SAMPLE_BITS-1:0]  sample_in,
  output logic [mdf_pkg::SAMPLE_BITS-1:0]  average,
  output logic [mdf_pkg::DIFF_BITS-1:0]    difference
);

  localparam int SB = mdf_pkg::SAMPLE_BITS;
  localparam int MB = mdf_pkg::SUM_BITS;
  localparam int CB = mdf_pkg::CNT_BITS;

  logic [SB-1:0]                   sample;
  logic [SB-1:0]                   old_entry;
  logic [SB-1:0]                   ram_rdata;
  logic [MB-1:0]                   window_sum;
  logic [mdf_pkg::IDX_BITS-1:0]    write_index;
  logic [CB-1:0]                   fill_count;
  logic                            sum_neg;
  logic [MB-1:0]                   quotient;
  logic [CB-1:0]                   remainder;
  logic [mdf_pkg::STEP_BITS-1:0]   step;
  logic [CB:0]                     rem_shift;
  logic [CB:0]                     trial;
  logic [MB-1:0]                   quot_signed;
  logic [mdf_pkg::DIFF_BITS-1:0]   diff_next;

  // ring store, one read then one write at the same slot
  mdf_ram #(
    .WIDTH(SB),
    .DEPTH(mdf_pkg::WINDOW_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.update),
    .addr (write_index),
    .wdata(sample),
    .rdata(ram_rdata)
  );

  // slots not yet written since reset read as zero
  assign old_entry = (fill_count == CB'(mdf_pkg::WINDOW_DEPTH)) ? ram_rdata : '0;

  // restoring divide, one quotient bit per cycle
  assign rem_shift = {remainder, quotient[MB-1]};
  assign trial     = rem_shift - {1'b0, fill_count};
  assign status.div_last = (step == mdf_pkg::STEP_BITS'(MB - 1));

  // result formatting
  assign quot_signed = sum_neg ? (~quotient + MB'(1)) : quotient;
  assign diff_next   = {quot_signed[SB-1], quot_signed[SB-1:0]} - {sample[SB-1], sample};

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum  <= '0;
      write_index <= '0;
      fill_count  <= '0;
    end else if (cmd.update) begin
      window_sum <= window_sum
                    - {{(MB - SB){old_entry[SB-1]}}, old_entry}
                    + {{(MB - SB){sample[SB-1]}}, sample};
      if (write_index == mdf_pkg::IDX_BITS'(mdf_pkg::WINDOW_DEPTH - 1)) begin
        write_index <= '0;
      end else begin
        write_index <= write_index + 1'b1;
      end
      if (fill_count != CB'(mdf_pkg::WINDOW_DEPTH)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // sample capture, divider and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample <= sample_in;
    end
    if (cmd.load) begin
      sum_neg   <= window_sum[MB-1];
      quotient  <= window_sum[MB-1] ? (~window_sum + MB'(1)) : window_sum;
      remainder <= '0;
      step      <= '0;
    end else if (cmd.step) begin
      if (!trial[CB]) begin
        remainder <= trial[CB-1:0];
      end else begin
        remainder <= rem_shift[CB-1:0];
      end
      quotient <= {quotient[MB-2:0], !trial[CB]};
      step     <= step + 1'b1;
    end
    if (cmd.load_out) begin
      average    <= quot_signed[SB-1:0];
      difference <= diff_next;
    end
  end

endmodule

[src/mean_difference_filter.sv]
// Each accepted input beat passes in order through accept, sum update, divider load,
// 29 divide steps (one quotient bit each) and output load, which waits until the output
// register is free, and no new sample is taken before that load; the next sample may be
// taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears sum, index, fill count and control; ring
// slots not yet written since reset read as zero through the fill count.
module mean_difference_filter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mdf_pkg::IN_DATA_BITS-1:0]   s_tdata,   // [23:0] sample
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mdf_pkg::OUT_DATA_BITS-1:0]  m_tdata    // [23:0] average, [48:24] difference
);

  localparam int SB = mdf_pkg::SAMPLE_BITS;
  localparam int DB = mdf_pkg::DIFF_BITS;

  mdf_pkg::cmd_t    cmd;
  mdf_pkg::status_t status;
  logic [SB-1:0]    average;
  logic [DB-1:0]    difference;

  mdf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .status  (status)
  );

  mdf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample_in (s_tdata[SB-1:0]),
    .average   (average),
    .difference(difference)
  );

  // pack result beat, zero padded
  always_comb begin
    m_tdata              = '0;
    m_tdata[SB-1:0]      = average;
    m_tdata[SB+DB-1:SB]  = difference;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_BITS   = mdf_pkg::SAMPLE_BITS;
  localparam int DIFF_BITS     = mdf_pkg::DIFF_BITS;
  localparam int WINDOW_DEPTH  = mdf_pkg::WINDOW_DEPTH;
  localparam int SUM_BITS      = mdf_pkg::SUM_BITS;
  localparam int IDX_BITS      = mdf_pkg::IDX_BITS;
  localparam int CNT_BITS      = mdf_pkg::CNT_BITS;
  localparam int IN_DATA_BITS  = mdf_pkg::IN_DATA_BITS;
  localparam int OUT_DATA_BITS = mdf_pkg::OUT_DATA_BITS;

  localparam int IDLE_LIMIT = 3000;   // cycles with no beat on either side
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 40;   // over the block's latency from input beat to result beat

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [DIFF_BITS-1:0]   difference;
    logic [SAMPLE_BITS-1:0] average;
  } mean_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_SPARSE,
    READY_LONG_STALL
  } stall_mode_t;

  // Window predictor plus queue of expected average/difference pairs
  class mean_window_scoreboard;
    logic signed [SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];
    logic signed [SUM_BITS-1:0]    window_total;
    logic [IDX_BITS-1:0]           slot;
    logic [CNT_BITS-1:0]           fill;
    mean_result_t                  expected_means[$];
    int                            errors;
    int                            checked;

    function new();
      foreach (ring[i]) ring[i] = '0;
      window_total = '0;
      slot = '0;
      fill = '0;
      errors = 0;
      checked = 0;
    endfunction

    // one accepted sample: update window, push expected result
    function void note_sample(logic [SAMPLE_BITS-1:0] raw);
      logic signed [SAMPLE_BITS-1:0] smp;
      logic signed [SUM_BITS-1:0]    quot;
      logic signed [DIFF_BITS-1:0]   diff;
      mean_result_t                  res;
      smp = $signed(raw);
      window_total = window_total - ring[slot] + smp;
      ring[slot] = smp;
      slot = (slot == IDX_BITS'(WINDOW_DEPTH - 1)) ? '0 : slot + 1'b1;
      if (fill < CNT_BITS'(WINDOW_DEPTH)) fill = fill + 1'b1;
      // signed divide truncates toward zero
      quot = window_total / $signed({1'b0, fill});
      diff = $signed(quot[SAMPLE_BITS-1:0]) - smp;
      res.average = quot[SAMPLE_BITS-1:0];
      res.difference = diff;
      expected_means.push_back(res);
    endfunction

    // one accepted result beat against the oldest expectation
    function void check_result(logic [OUT_DATA_BITS-1:0] data);
      mean_result_t want;
      mean_result_t got;
      got.average = data[SAMPLE_BITS-1:0];
      got.difference = data[SAMPLE_BITS+DIFF_BITS-1:SAMPLE_BITS];
      if (expected_means.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: average %0d difference %0d",
                 $time, $signed(got.average), $signed(got.difference));
        return;
      end
      want = expected_means.pop_front();
      checked++;
      if (got.average !== want.average) begin
        errors++;
        $display("%0t: average mismatch: expected %0d actual %0d", $time,
                 $signed(want.average), $signed(got.average));
      end
      if (got.difference !== want.difference) begin
        errors++;
        $display("%0t: difference mismatch: expected %0d actual %0d", $time,
                 $signed(want.difference), $signed(got.difference));
      end
    endfunction

    function int pending();
      return expected_means.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;    // [23:0] sample
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;        // [23:0] average, [48:24] difference

  mean_window_scoreboard sb;
  int samples_in = 0;
  int idle_count = 0;

  mean_difference_filter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_sample(s_tdata[SAMPLE_BITS-1:0]);
        samples_in++;
      end
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // receiver back-pressure in randomly chosen modes
  stall_mode_t stall_mode = READY_ALWAYS;
  int mode_left = 0;
  int hold_left = 0;
  logic [1:0] sparse_phase = '0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    sparse_phase <= sparse_phase + 1'b1;
    case (stall_mode)
      READY_ALWAYS: begin
        m_tready <= 1'b1;
      end
      READY_RANDOM: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      READY_SPARSE: begin
        m_tready <= (sparse_phase == 2'd0);
      end
      default: begin
        // long low stretches, short high windows
        if (hold_left == 0) begin
          m_tready <= ~m_tready;
          hold_left <= m_tready ? $urandom_range(1, 80) : $urandom_range(1, 6);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  // one sample beat; valid stays high on return
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_BITS'(value);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // random sample mix: full range, near zero, extremes, constant runs
  logic [SAMPLE_BITS-1:0] last_sample = '0;
  int run_left = 0;

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] v;
    if (run_left > 0) begin
      run_left--;
      return last_sample;
    end
    case ($urandom_range(0, 29))
      0: begin
        // hold one extreme long enough to fill the whole window
        v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        run_left = $urandom_range(32, 45);
      end
      1, 2: begin
        v = last_sample;
        run_left = $urandom_range(2, 10);
      end
      3, 4, 5: v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      6, 7, 8: v = SAMPLE_BITS'($signed($urandom_range(0, 510)) - 255);
      9, 10: v = SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 15));
      11, 12: v = SAMPLE_MIN + SAMPLE_BITS'($urandom_range(0, 15));
      default: v = SAMPLE_BITS'($urandom());
    endcase
    last_sample = v;
    return v;
  endfunction

  initial begin
    logic [SAMPLE_BITS-1:0] directed [$];
    int sent;
    int burst;

    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: partial fill with zeros in the sum, extremes, sign edges
    directed = {24'h000000, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
                SAMPLE_MIN, SAMPLE_MIN, 24'hFFFFFF, 24'h000001, SAMPLE_MAX, SAMPLE_MIN,
                24'h400000, 24'hC00000, 24'h555555, 24'hAAAAAA, 24'hFFFFFE, 24'h000002,
                24'h000000, SAMPLE_MAX, 24'hFFFFFF, 24'h7FFFFE, 24'h800001, 24'h000003};
    foreach (directed[i]) send_sample(directed[i]);
    pause_sender(5);

    // random bursts with gaps of random length
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      repeat (burst) begin
        send_sample(pick_sample());
        sent++;
      end
      pause_sender(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 45));
    end

    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d samples, %0d result beats checked, through window fill and wrap,",
             samples_in, sb.checked);
    $display("full-scale windows and random gaps and back-pressure on both sides");
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
